// ===== rtl/ffcba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ffcba_pkg;

  localparam int unsigned BLOCK_COUNT = 512;
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int unsigned REQ_W   = 22;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned GRANT_W = 10;

  // The map is held as words of WORD_BITS blocks each.
  localparam int unsigned WORD_BITS  = 8;
  localparam int unsigned WORD_SEL_W = $clog2(WORD_BITS);
  localparam int unsigned WORD_COUNT = BLOCK_COUNT / WORD_BITS;
  localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);

  // Rounded block count of a request, wide enough for the largest request.
  localparam int unsigned BLK_W = REQ_W + 1 - BLOCK_SHIFT;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NO_ROOM = 1'b1;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic wr;
    logic setup_mark;
    logic finish;
    logic fail;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic range_empty;
    logic zero_req;
    logic too_big;
    logic hit;
    logic rd_done;
    logic wr_last;
  } dp_sts_t;

endpackage

// ===== rtl/ffcba_dp.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator datapath
// Holds the used/free map memory, the run scanner, the range writer and the
// result registers.
// ----------------------------------------------------------------------------
module ffcba_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ffcba_pkg::dp_cmd_t                cmd,
  output ffcba_pkg::dp_sts_t                sts,
  input  logic                              in_action,
  input  logic [ffcba_pkg::REQ_W-1:0]       in_request_bytes,
  input  logic [ffcba_pkg::IDX_W-1:0]       in_free_first,
  input  logic [ffcba_pkg::IDX_W-1:0]       in_free_last,
  output logic                              out_valid,
  output logic                              out_status,
  output logic [ffcba_pkg::IDX_W-1:0]       out_start_block,
  output logic [ffcba_pkg::GRANT_W-1:0]     out_granted_blocks
);

  logic [ffcba_pkg::WORD_BITS-1:0]  map_mem [ffcba_pkg::WORD_COUNT];

  logic                             action_r;
  logic [ffcba_pkg::BLK_W-1:0]      want_r;
  logic [ffcba_pkg::IDX_W-1:0]      lo_r;
  logic [ffcba_pkg::IDX_W-1:0]      hi_r;
  logic                             set_r;
  logic [ffcba_pkg::ADDR_W-1:0]     addr_r;
  logic [ffcba_pkg::ADDR_W-1:0]     ev_addr_r;
  logic                             rd_done_r;
  logic [ffcba_pkg::GRANT_W-1:0]    run_r;
  logic [ffcba_pkg::IDX_W-1:0]      start_r;
  logic [ffcba_pkg::WORD_BITS-1:0]  rd_data_r;
  logic                             out_valid_r;
  logic                             out_status_r;
  logic [ffcba_pkg::IDX_W-1:0]      out_start_r;
  logic [ffcba_pkg::GRANT_W-1:0]    out_granted_r;

  logic [ffcba_pkg::BLK_W-1:0]      want_nxt;
  logic [ffcba_pkg::GRANT_W-1:0]    run_nxt;
  logic [ffcba_pkg::IDX_W-1:0]      start_nxt;
  logic                             hit;
  logic [ffcba_pkg::WORD_BITS-1:0]  wmask;

  // Round the byte count up to whole blocks.
  assign want_nxt = ffcba_pkg::BLK_W'(
      ({1'b0, in_request_bytes} + (ffcba_pkg::REQ_W + 1)'(ffcba_pkg::BLOCK_BYTES - 1))
      >> ffcba_pkg::BLOCK_SHIFT);

  // Walk the eight blocks of the fetched word, carrying the free run from
  // the previous word. The first block that completes a long enough run
  // fixes the start.
  always_comb begin
    logic [ffcba_pkg::IDX_W-1:0]   idx;
    logic [ffcba_pkg::GRANT_W-1:0] end_plus;
    run_nxt   = run_r;
    hit       = 1'b0;
    start_nxt = start_r;
    end_plus  = '0;
    for (int j = 0; j < ffcba_pkg::WORD_BITS; j++) begin
      idx = {ev_addr_r, ffcba_pkg::WORD_SEL_W'(j)};
      if (!rd_data_r[j]) begin
        run_nxt = run_nxt + 1'b1;
      end else begin
        run_nxt = '0;
      end
      if (!hit && (run_nxt >= want_r[ffcba_pkg::GRANT_W-1:0])) begin
        hit       = 1'b1;
        end_plus  = {1'b0, idx} + 1'b1;
        start_nxt = ffcba_pkg::IDX_W'(end_plus - want_r[ffcba_pkg::GRANT_W-1:0]);
      end
    end
  end

  always_comb begin
    logic [ffcba_pkg::IDX_W-1:0] idx;
    for (int j = 0; j < ffcba_pkg::WORD_BITS; j++) begin
      idx      = {addr_r, ffcba_pkg::WORD_SEL_W'(j)};
      wmask[j] = (idx >= lo_r) && (idx <= hi_r);
    end
  end

  always_comb begin
    sts.is_free     = (action_r == ffcba_pkg::ACT_FREE);
    sts.range_empty = (hi_r < lo_r);
    sts.zero_req    = (want_r == '0);
    sts.too_big     = (want_r > ffcba_pkg::BLK_W'(ffcba_pkg::BLOCK_COUNT));
    sts.hit         = hit;
    sts.rd_done     = rd_done_r;
    sts.wr_last     = (addr_r == hi_r[ffcba_pkg::IDX_W-1:ffcba_pkg::WORD_SEL_W]);
  end

  // Control registers. After reset the range covers the whole map with a
  // clear value, so the first write pass empties it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      lo_r        <= '0;
      hi_r        <= ffcba_pkg::IDX_W'(ffcba_pkg::BLOCK_COUNT - 1);
      set_r       <= 1'b0;
      rd_done_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        lo_r      <= in_free_first;
        hi_r      <= in_free_last;
        set_r     <= 1'b0;
        rd_done_r <= 1'b0;
        if (in_action == ffcba_pkg::ACT_FREE) begin
          addr_r <= in_free_first[ffcba_pkg::IDX_W-1:ffcba_pkg::WORD_SEL_W];
        end else begin
          addr_r <= '0;
        end
      end else if (cmd.setup_mark) begin
        lo_r   <= start_r;
        hi_r   <= ffcba_pkg::IDX_W'(start_r + want_r[ffcba_pkg::GRANT_W-1:0] - 1'b1);
        set_r  <= 1'b1;
        addr_r <= start_r[ffcba_pkg::IDX_W-1:ffcba_pkg::WORD_SEL_W];
      end else if (cmd.rd || cmd.wr) begin
        addr_r <= addr_r + 1'b1;
        if (cmd.rd && (addr_r == ffcba_pkg::ADDR_W'(ffcba_pkg::WORD_COUNT - 1))) begin
          rd_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      want_r   <= want_nxt;
      run_r    <= '0;
      start_r  <= '0;
    end else if (cmd.eval) begin
      run_r <= run_nxt;
      if (hit) begin
        start_r <= start_nxt;
      end
    end
    if (cmd.rd) begin
      ev_addr_r <= addr_r;
    end
    if (cmd.finish) begin
      out_status_r <= cmd.fail ? ffcba_pkg::ST_NO_ROOM : ffcba_pkg::ST_DONE;
      out_start_r  <= cmd.fail ? '0 : start_r;
      if (cmd.fail || (action_r == ffcba_pkg::ACT_FREE)) begin
        out_granted_r <= '0;
      end else begin
        out_granted_r <= want_r[ffcba_pkg::GRANT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      for (int j = 0; j < ffcba_pkg::WORD_BITS; j++) begin
        if (wmask[j]) begin
          map_mem[addr_r][j] <= set_r;
        end
      end
    end
    if (cmd.rd) begin
      rd_data_r <= map_mem[addr_r];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_start_block    = out_start_r;
  assign out_granted_blocks = out_granted_r;

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ffcba_pkg::ST_NO_ROOM)) |->
      ((out_start_block == '0) && (out_granted_blocks == '0)))
    else $error("failed allocation reports a non-zero run");

  a_grant_in_disk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_granted_blocks != '0)) |->
      (({1'b0, out_start_block} + out_granted_blocks) <= ffcba_pkg::BLOCK_COUNT))
    else $error("granted run runs past the end of the map");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |->
      ((addr_r >= lo_r[ffcba_pkg::IDX_W-1:ffcba_pkg::WORD_SEL_W]) &&
       (addr_r <= hi_r[ffcba_pkg::IDX_W-1:ffcba_pkg::WORD_SEL_W])))
    else $error("map write outside the current block range");

endmodule

// ===== rtl/ffcba_ctrl.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator controller
// Sequences the clearing pass, the map scan, the mark and free passes and
// the result strobe.
// ----------------------------------------------------------------------------
module ffcba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ffcba_pkg::dp_sts_t sts,
  output ffcba_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MARKSET,
    S_WRITE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_free) begin
          if (sts.range_empty) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_WRITE;
          end
        end else if (sts.zero_req) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.too_big) begin
          cmd.finish = 1'b1;
          cmd.fail   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Each cycle judges the word fetched in the previous one.
        cmd.eval = 1'b1;
        if (sts.hit) begin
          state_nxt = S_MARKSET;
        end else if (sts.rd_done) begin
          cmd.finish = 1'b1;
          cmd.fail   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_MARKSET: begin
        cmd.setup_mark = 1'b1;
        state_nxt      = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== rtl/first_fit_contiguous_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// First-fit contiguous block allocator
// Free clears the map words its range touches, eight blocks a word; a reversed
//   range, a zero or an oversize request ends without touching the map; allocate
//   scans 1 to 64 map words, then marks the granted run; all 64 are read if no fit.
// Throughput: one item at a time; busy falls as the one-cycle strobe is issued,
//   so the next transfer can be taken at the edge that ends it. No receiver stall.
// After reset a clearing pass empties the map with busy high.
// ----------------------------------------------------------------------------
module first_fit_contiguous_block_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [ffcba_pkg::REQ_W-1:0]   in_request_bytes,
  input  logic [ffcba_pkg::IDX_W-1:0]   in_free_first,
  input  logic [ffcba_pkg::IDX_W-1:0]   in_free_last,
  output logic                          out_valid,
  output logic                          out_status,
  output logic [ffcba_pkg::IDX_W-1:0]   out_start_block,
  output logic [ffcba_pkg::GRANT_W-1:0] out_granted_blocks
);

  ffcba_pkg::dp_cmd_t cmd;
  ffcba_pkg::dp_sts_t sts;

  ffcba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffcba_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_action),
    .in_request_bytes   (in_request_bytes),
    .in_free_first      (in_free_first),
    .in_free_last       (in_free_last),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_start_block    (out_start_block),
    .out_granted_blocks (out_granted_blocks)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the first-fit contiguous block allocator
// Sends allocate and free commands through the start/busy transfer and keeps
// its own copy of the used/free map to predict every result. Directed tests
// cover rounding, oversize requests, range frees and a full disk. Random
// phases then run with and without sender idling. A checker compares each
// result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 150;

  typedef struct packed {
    logic                        action;
    logic [ffcba_pkg::REQ_W-1:0] bytes;
    logic [ffcba_pkg::IDX_W-1:0] free_first;
    logic [ffcba_pkg::IDX_W-1:0] free_last;
  } alloc_cmd_t;

  typedef struct packed {
    logic                          status;
    logic [ffcba_pkg::IDX_W-1:0]   start_block;
    logic [ffcba_pkg::GRANT_W-1:0] granted;
  } alloc_resp_t;

  typedef struct packed {
    logic [ffcba_pkg::IDX_W-1:0]   first_block;
    logic [ffcba_pkg::GRANT_W-1:0] count;
  } run_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_action;
  logic [ffcba_pkg::REQ_W-1:0]   in_request_bytes;
  logic [ffcba_pkg::IDX_W-1:0]   in_free_first;
  logic [ffcba_pkg::IDX_W-1:0]   in_free_last;
  logic                          out_valid;
  logic                          out_status;
  logic [ffcba_pkg::IDX_W-1:0]   out_start_block;
  logic [ffcba_pkg::GRANT_W-1:0] out_granted_blocks;

  bit [ffcba_pkg::BLOCK_COUNT-1:0] block_used;
  alloc_resp_t                     pending_grants[$];
  run_t                            live_runs[$];
  int unsigned                     mismatches = 0;
  int unsigned                     cycle_count = 0;

  first_fit_contiguous_block_allocator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_request_bytes   (in_request_bytes),
    .in_free_first      (in_free_first),
    .in_free_last       (in_free_last),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_start_block    (out_start_block),
    .out_granted_blocks (out_granted_blocks)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one command to the local map and returns the result it should give.
  function automatic alloc_resp_t apply_to_map(input alloc_cmd_t c);
    alloc_resp_t r;
    int unsigned want;
    int unsigned run;
    int unsigned i;
    r.status      = ffcba_pkg::ST_DONE;
    r.start_block = '0;
    r.granted     = '0;
    if (c.action == ffcba_pkg::ACT_FREE) begin
      if (c.free_last >= c.free_first)
        for (i = c.free_first; i <= c.free_last; i++) block_used[i] = 1'b0;
      return r;
    end
    want = (c.bytes + ffcba_pkg::BLOCK_BYTES - 1) / ffcba_pkg::BLOCK_BYTES;
    if (want == 0) return r;
    if (want > ffcba_pkg::BLOCK_COUNT) begin
      r.status = ffcba_pkg::ST_NO_ROOM;
      return r;
    end
    run = 0;
    for (i = 0; i < ffcba_pkg::BLOCK_COUNT; i++) begin
      if (block_used[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == want) begin
          r.start_block = ffcba_pkg::IDX_W'(i + 1 - want);
          r.granted     = ffcba_pkg::GRANT_W'(want);
          for (int unsigned j = i + 1 - want; j <= i; j++) block_used[j] = 1'b1;
          return r;
        end
      end
    end
    r.status = ffcba_pkg::ST_NO_ROOM;
    return r;
  endfunction

  function automatic alloc_cmd_t alloc_cmd(input logic [ffcba_pkg::REQ_W-1:0] bytes);
    alloc_cmd_t c;
    c.action     = ffcba_pkg::ACT_ALLOC;
    c.bytes      = bytes;
    c.free_first = ffcba_pkg::IDX_W'($urandom);
    c.free_last  = ffcba_pkg::IDX_W'($urandom);
    return c;
  endfunction

  function automatic alloc_cmd_t free_cmd(input int unsigned first_blk,
                                          input int unsigned last_blk);
    alloc_cmd_t c;
    c.action     = ffcba_pkg::ACT_FREE;
    c.bytes      = ffcba_pkg::REQ_W'($urandom);
    c.free_first = ffcba_pkg::IDX_W'(first_blk);
    c.free_last  = ffcba_pkg::IDX_W'(last_blk);
    return c;
  endfunction

  // Random size in bytes that rounds up to exactly the given block count.
  function automatic logic [ffcba_pkg::REQ_W-1:0] bytes_for(input int unsigned blocks);
    return ffcba_pkg::REQ_W'((blocks - 1) * ffcba_pkg::BLOCK_BYTES
                             + $urandom_range(1, ffcba_pkg::BLOCK_BYTES));
  endfunction

  // Cycles the sender stays idle after a transfer, each cycle idle with the
  // given chance.
  function automatic int unsigned sender_gap(input int unsigned idle_pct);
    int unsigned g;
    g = 0;
    while (g < 40 && $urandom_range(0, 99) < idle_pct) g++;
    return g;
  endfunction

  // Appends a prediction to the queue of results still to come.
  task automatic queue_grant(input alloc_resp_t r);
    pending_grants.insert(pending_grants.size(), r);
  endtask

  // Keeps a granted run so that a later free can hand it back.
  task automatic keep_run(input run_t rn);
    live_runs.insert(live_runs.size(), rn);
  endtask

  // Start stays high between back-to-back commands; this task lowers it only when a
  // gap follows, so it never gets two assignments in one time step.
  task automatic send_item(input alloc_cmd_t c, input int unsigned gap);
    alloc_resp_t r;
    run_t        rn;
    start            <= 1'b1;
    in_action        <= c.action;
    in_request_bytes <= c.bytes;
    in_free_first    <= c.free_first;
    in_free_last     <= c.free_last;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_to_map(c);
    queue_grant(r);
    if (c.action == ffcba_pkg::ACT_ALLOC && r.status == ffcba_pkg::ST_DONE &&
        r.granted != 0) begin
      rn.first_block = r.start_block;
      rn.count       = r.granted;
      keep_run(rn);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lowers start and waits on the clock before it checks the queue, so the next command
  // is driven in a later time step.
  task automatic wait_for_grants();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    alloc_resp_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d start %0d granted %0d",
                 $time, out_status, out_start_block, out_granted_blocks);
        mismatches++;
      end else begin
        exp_r = pending_grants.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("start_block", exp_r.start_block, out_start_block);
        check_field("granted_blocks", exp_r.granted, out_granted_blocks);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL first_fit_contiguous_block_allocator_top");
      $finish;
    end
  end

  task automatic test_rounding();
    send_item(alloc_cmd(0), 0);
    send_item(alloc_cmd(1), 0);
    send_item(alloc_cmd(ffcba_pkg::BLOCK_BYTES), 0);
    send_item(alloc_cmd(ffcba_pkg::BLOCK_BYTES + 1), 0);
    send_item(alloc_cmd(5 * ffcba_pkg::BLOCK_BYTES + 7), 0);
    send_item(alloc_cmd({ffcba_pkg::REQ_W{1'b1}}), 0);
    send_item(alloc_cmd(ffcba_pkg::BLOCK_COUNT * ffcba_pkg::BLOCK_BYTES + 1), 0);
    send_item(alloc_cmd(ffcba_pkg::BLOCK_COUNT * ffcba_pkg::BLOCK_BYTES), 0);
    wait_for_grants();
  endtask

  task automatic test_free_ranges();
    send_item(free_cmd(0, 0), 0);
    send_item(alloc_cmd(1), 0);
    send_item(free_cmd(5, 3), 0);
    send_item(free_cmd(ffcba_pkg::BLOCK_COUNT - 1, ffcba_pkg::BLOCK_COUNT - 1), 0);
    send_item(free_cmd(0, ffcba_pkg::BLOCK_COUNT - 1), 0);
    wait_for_grants();
  endtask

  task automatic test_full_disk();
    send_item(alloc_cmd(ffcba_pkg::BLOCK_COUNT * ffcba_pkg::BLOCK_BYTES), 0);
    send_item(alloc_cmd(1), 0);
    send_item(free_cmd(200, 300), 0);
    send_item(alloc_cmd(101 * ffcba_pkg::BLOCK_BYTES), 0);
    send_item(alloc_cmd(1), 0);
    send_item(free_cmd(1, ffcba_pkg::BLOCK_COUNT - 1), 0);
    send_item(alloc_cmd(bytes_for(ffcba_pkg::BLOCK_COUNT - 1)), 0);
    send_item(free_cmd(0, ffcba_pkg::BLOCK_COUNT - 1), 0);
    wait_for_grants();
  endtask

  // Mostly small allocations and frees of runs that were granted earlier, so
  // the map fragments; the rest are odd sizes, stray and reversed ranges.
  function automatic alloc_cmd_t next_random_command();
    int unsigned used;
    int unsigned alloc_pct;
    int unsigned sel;
    int unsigned idx;
    int unsigned a;
    logic [ffcba_pkg::REQ_W-1:0] bytes;
    run_t rn;
    used      = $countones(block_used);
    alloc_pct = (used < 256) ? 70 : ((used < 448) ? 45 : 25);
    if ($urandom_range(0, 99) < alloc_pct) begin
      sel = $urandom_range(0, 99);
      if (sel < 2)       bytes = '0;
      else if (sel < 55) bytes = bytes_for($urandom_range(1, 8));
      else if (sel < 80) bytes = bytes_for($urandom_range(1, 64));
      else if (sel < 90) bytes = bytes_for($urandom_range(65, ffcba_pkg::BLOCK_COUNT));
      else if (sel < 95)
        bytes = ffcba_pkg::REQ_W'($urandom_range(0, ffcba_pkg::BLOCK_COUNT)
                                  * ffcba_pkg::BLOCK_BYTES + $urandom_range(0, 2) - 1);
      else               bytes = ffcba_pkg::REQ_W'($urandom);
      return alloc_cmd(bytes);
    end
    sel = $urandom_range(0, 99);
    if (sel < 60 && live_runs.size() != 0) begin
      idx = $urandom_range(0, live_runs.size() - 1);
      rn  = live_runs[idx];
      live_runs.delete(idx);
      return free_cmd(rn.first_block, rn.first_block + rn.count - 1);
    end
    if (sel < 85) begin
      a = $urandom_range(0, ffcba_pkg::BLOCK_COUNT - 1);
      return free_cmd(a, (a + $urandom_range(0, 31) > ffcba_pkg::BLOCK_COUNT - 1) ?
                         ffcba_pkg::BLOCK_COUNT - 1 : a + $urandom_range(0, 31));
    end
    if (sel < 95) begin
      a = $urandom_range(1, ffcba_pkg::BLOCK_COUNT - 1);
      return free_cmd(a, $urandom_range(0, a - 1));
    end
    return free_cmd($urandom_range(0, ffcba_pkg::BLOCK_COUNT - 1),
                    $urandom_range(0, ffcba_pkg::BLOCK_COUNT - 1));
  endfunction

  task automatic test_random(input int unsigned idle_pct, input int unsigned n_items);
    for (int unsigned n = 0; n < n_items; n++) begin
      send_item(next_random_command(), sender_gap(idle_pct));
      // Hold the sender off now and then until every result has come back.
      if (n == n_items / 2 || $urandom_range(0, 99) == 0) wait_for_grants();
    end
    wait_for_grants();
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_action        <= ffcba_pkg::ACT_ALLOC;
    in_request_bytes <= '0;
    in_free_first    <= '0;
    in_free_last     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_rounding();
    test_free_ranges();
    test_full_disk();
    test_random(0, 500);
    test_random(79, 500);
    test_random(16, 500);

    wait_for_grants();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS first_fit_contiguous_block_allocator_top");
    end else begin
      $display("FAIL first_fit_contiguous_block_allocator_top");
    end
    $finish;
  end

endmodule
